>>> rtl/qlhr_pkg.sv
// Package for the quoted literal hash replacer: channel item types, the
// FNV-1a constants and the decimal step table used by the digit emitter.
// No dependencies.
`default_nettype none

package qlhr_pkg;

    localparam int HASH_BITS_MAX = 20;
    localparam int DEC_W         = HASH_BITS_MAX;
    localparam int MAX_DIGITS    = 7;
    localparam int POS_W         = $clog2(MAX_DIGITS);
    localparam int DIGIT_W       = 4;
    // Steps reach 9 * 10^6, which needs more bits than the value itself.
    localparam int STEP_W        = 24;

    localparam logic [63:0] FNV_BASIS     = 64'hcbf29ce484222325;
    // Only the low part of the prime below bit 40 matters for the low hash bits.
    localparam logic [8:0]  FNV_PRIME_LOW = 9'h1b3;
    localparam logic [7:0]  QUOTE_CHAR    = 8'h27;
    localparam logic [7:0]  ZERO_CHAR     = 8'h30;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_item_t;

    // Work handed from the scanner to the emitter.
    typedef struct packed {
        logic             is_digits;
        logic [7:0]       char_val;
        logic [DEC_W-1:0] value;
        logic             last;
    } cmd_t;

    // step_tbl[p][d] = d * 10^p
    typedef logic [MAX_DIGITS-1:0][9:0][STEP_W-1:0] step_tbl_t;

    function automatic step_tbl_t build_steps();
        step_tbl_t t;
        int        pw;
        pw = 1;
        for (int p = 0; p < MAX_DIGITS; p++)
        begin
            for (int d = 0; d < 10; d++)
            begin
                t[p][d] = STEP_W'(d * pw);
            end
            pw = pw * 10;
        end
        return t;
    endfunction

    localparam step_tbl_t STEP_TBL = build_steps();

endpackage

`default_nettype wire

>>> rtl/qlhr_scan.sv
// Scanner stage of the quoted literal hash replacer: tracks quoting, keeps the
// low bits of the FNV-1a hash and registers at most one command per input byte.
// Depends on qlhr_pkg.
`default_nettype none

module qlhr_scan #(
    parameter int HASH_BITS = qlhr_pkg::HASH_BITS_MAX
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire qlhr_pkg::in_item_t in_data,
    output logic                   cmd_valid,
    input  wire logic              cmd_ready,
    output qlhr_pkg::cmd_t         cmd
);
    import qlhr_pkg::*;

    localparam logic [HASH_BITS-1:0] BASIS_LOW = FNV_BASIS[HASH_BITS-1:0];

    logic                 inside_reg, inside_next;
    logic [HASH_BITS-1:0] hash_reg, hash_next;
    logic                 cmd_valid_reg, cmd_valid_next;
    cmd_t                 cmd_reg, cmd_next;

    logic                 accept;
    logic [31:0]          byte_ext;
    logic [HASH_BITS-1:0] mixed;
    logic [HASH_BITS+8:0] prod;
    logic [HASH_BITS-1:0] hash_upd;
    logic                 is_quote;

    assign in_ready  = !cmd_valid_reg || cmd_ready;
    assign accept    = in_valid && in_ready;
    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

    // Multiplying by the prime modulo 2^64 leaves the low bits depending only
    // on the low bits, and the 2^40 term of the prime never reaches them.
    assign byte_ext = 32'(in_data.in_byte);
    assign mixed    = hash_reg ^ byte_ext[HASH_BITS-1:0];
    assign prod     = (HASH_BITS+9)'(mixed) * (HASH_BITS+9)'(FNV_PRIME_LOW);
    assign hash_upd = prod[HASH_BITS-1:0];
    assign is_quote = (in_data.in_byte == QUOTE_CHAR);

    always_comb
    begin
        inside_next    = inside_reg;
        hash_next      = hash_reg;
        cmd_valid_next = cmd_valid_reg;
        cmd_next       = cmd_reg;

        if (cmd_valid_reg && cmd_ready)
        begin
            cmd_valid_next = 1'b0;
        end

        if (accept)
        begin
            cmd_valid_next     = 1'b0;
            cmd_next.is_digits = 1'b1;
            cmd_next.char_val  = in_data.in_byte;
            cmd_next.value     = DEC_W'(hash_reg);
            cmd_next.last      = in_data.end_of_text;

            if (!inside_reg)
            begin
                if (is_quote)
                begin
                    inside_next    = 1'b1;
                    hash_next      = BASIS_LOW;
                    cmd_next.value = DEC_W'(BASIS_LOW);
                    cmd_valid_next = in_data.end_of_text;
                end
                else
                begin
                    cmd_next.is_digits = 1'b0;
                    cmd_valid_next     = 1'b1;
                end
            end
            else
            begin
                if (is_quote)
                begin
                    inside_next    = 1'b0;
                    cmd_valid_next = 1'b1;
                end
                else
                begin
                    hash_next      = hash_upd;
                    cmd_next.value = DEC_W'(hash_upd);
                    cmd_valid_next = in_data.end_of_text;
                end
            end

            if (in_data.end_of_text)
            begin
                inside_next = 1'b0;
                hash_next   = BASIS_LOW;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg    <= 1'b0;
            hash_reg      <= BASIS_LOW;
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            inside_reg    <= inside_next;
            hash_reg      <= hash_next;
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

`default_nettype wire

>>> rtl/qlhr_emit.sv
// Emitter stage of the quoted literal hash replacer: drives the output
// register with passed bytes or decimal hash digits, one per unstalled cycle.
// Depends on qlhr_pkg.
`default_nettype none

module qlhr_emit (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    output logic                cmd_ready,
    input  wire qlhr_pkg::cmd_t cmd,
    output logic                out_valid,
    input  wire logic           out_ready,
    output qlhr_pkg::out_item_t out_data
);
    import qlhr_pkg::*;

    logic             out_valid_reg, out_valid_next;
    out_item_t        out_data_reg, out_data_next;
    logic             pend_reg, pend_next;
    logic [DEC_W-1:0] rem_reg, rem_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             last_reg, last_next;

    logic                       out_load;
    logic [9:0][STEP_W-1:0]     row;
    logic [DIGIT_W-1:0]         digit;
    logic [POS_W-1:0]           top_pos;

    assign out_load  = !out_valid_reg || out_ready;
    assign cmd_ready = !pend_reg && out_load;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Digit at the current position: how many multiples of 10^pos fit.
    always_comb
    begin
        row   = STEP_TBL[pos_reg];
        digit = '0;
        for (int d = 1; d < 10; d++)
        begin
            if (STEP_W'(rem_reg) >= row[d])
            begin
                digit = DIGIT_W'(d);
            end
        end
    end

    // Position of the leading digit of a new value.
    always_comb
    begin
        top_pos = '0;
        for (int p = 1; p < MAX_DIGITS; p++)
        begin
            if (STEP_W'(cmd.value) >= STEP_TBL[p][1])
            begin
                top_pos = POS_W'(p);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        pend_next      = pend_reg;
        rem_next       = rem_reg;
        pos_next       = pos_reg;
        last_next      = last_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (pend_reg && out_load)
        begin
            out_valid_next         = 1'b1;
            out_data_next.out_byte = ZERO_CHAR + 8'(digit);
            out_data_next.out_last = last_reg && (pos_reg == '0);
            rem_next               = rem_reg - row[digit][DEC_W-1:0];
            pos_next               = pos_reg - 1'b1;
            if (pos_reg == '0)
            begin
                pend_next = 1'b0;
            end
        end
        else if (cmd_valid && cmd_ready)
        begin
            if (!cmd.is_digits)
            begin
                out_valid_next         = 1'b1;
                out_data_next.out_byte = cmd.char_val;
                out_data_next.out_last = cmd.last;
            end
            else
            begin
                pend_next = 1'b1;
                rem_next  = cmd.value;
                pos_next  = top_pos;
                last_next = cmd.last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        rem_reg      <= rem_next;
        pos_reg      <= pos_next;
        last_reg     <= last_next;
    end

endmodule

`default_nettype wire

>>> rtl/quoted_literal_hash_replacer_unit.sv
// Top level of the quoted literal hash replacer: scanner stage and emitter.
// Depends on qlhr_pkg, qlhr_scan and qlhr_emit.
`default_nettype none

// The unit takes an expression text one byte per transfer and passes every
// byte outside single quotes straight through. A quoted literal is replaced
// by the decimal text of the low HASH_BITS bits of its 64-bit FNV-1a hash,
// most significant digit first and without leading zeros; the quotes are
// dropped. A literal still open at end of text is emitted as digits too, and
// the final result of each text carries out_last. The input takes one byte
// per cycle as long as results drain: a passed byte is written out as it is,
// while a closed literal is set up in the emitter and then written as
// digits (one to seven). The scanner holds one finished command between
// the two sides, so a new byte is still taken while a result waits at the
// output; once that command slot is full the input stalls until the emitter
// frees it. A passed byte goes through the command and output registers; a
// literal's first digit also waits for the emitter's digit setup registers.
// There are no configuration registers and no clearing pass after reset.
module quoted_literal_hash_replacer_unit #(
    parameter int HASH_BITS = qlhr_pkg::HASH_BITS_MAX
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire qlhr_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output qlhr_pkg::out_item_t      out_data
);
    import qlhr_pkg::*;

    // Command slot between the scanner and the emitter.
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    // The scanner follows the quoting and keeps the running hash; it issues
    // a pass-through byte, a value to print, or nothing for each byte.
    qlhr_scan #(
        .HASH_BITS (HASH_BITS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // The emitter owns the output register and walks a value's decimal digits
    // one per cycle unless stalled, against a constant table of digit steps.
    qlhr_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
